>>> src/assert_macros.svh
// assertion macros shared by the s-box rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbf assertion failed");

// next-cycle implication, disabled while reset is low
`define SBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbf assertion failed");

`endif

>>> src/sbf_pkg.sv
// shared types, constants and gf(2^8) functions for the forward s-box
// no dependencies
package sbf_pkg;

    localparam logic [8:0] GF_POLY    = 9'h11B;
    localparam logic [7:0] AFFINE_ADD = 8'h63;
    localparam logic [7:0] ROW_MASK [8] = '{
        8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C, 8'hF8
    };

    typedef struct packed {
        logic en;
        logic vld;
    } t_dp_ctl;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] t;
        acc = '0;
        t   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ t;
            end
            t = {t[6:0], 1'b0} ^ (t[7] ? GF_POLY[7:0] : 8'h00);
        end
        return acc;
    endfunction

    // squaring is linear: spread the bits, then reduce
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[2*i] = a[i];
        end
        for (int j = 14; j >= 8; j--) begin
            if (p[j]) begin
                p[j-:9] = p[j-:9] ^ GF_POLY;
            end
        end
        return p[7:0];
    endfunction

    function automatic logic [7:0] aes_affine(input logic [7:0] v);
        logic [7:0] res;
        for (int k = 0; k < 8; k++) begin
            res[k] = (^(v & ROW_MASK[k])) ^ AFFINE_ADD[k];
        end
        return res;
    endfunction

endpackage

>>> src/sbf_pipe.sv
// four-stage datapath: inverse as a^254 by an addition chain, then the affine map
// depends on sbf_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbf_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sbf_pkg::t_dp_ctl i_ctl,
    input  logic [7:0]      i_byte,
    output logic            o_vld,
    output logic [7:0]      o_byte
);
    import sbf_pkg::*;

    logic [3:0] r_vld;
    logic [7:0] r_s1_a2, r_s1_a3;
    logic [7:0] r_s2_a2, r_s2_a12, r_s2_a15;
    logic [7:0] r_s3_a2, r_s3_a252;
    logic [7:0] r_s4_sub;

    logic [7:0] n_s1_a2, n_s1_a3;
    logic [7:0] n_s2_a12, n_s2_a15;
    logic [7:0] n_s3_a252;
    logic [7:0] n_s4_sub;

    always_comb begin
        n_s1_a2   = gf_sq(i_byte);
        n_s1_a3   = gf_mul(n_s1_a2, i_byte);
        n_s2_a12  = gf_sq(gf_sq(r_s1_a3));
        n_s2_a15  = gf_mul(n_s2_a12, r_s1_a3);
        n_s3_a252 = gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(r_s2_a15)))), r_s2_a12);
        n_s4_sub  = aes_affine(gf_mul(r_s3_a252, r_s3_a2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1_a2   <= n_s1_a2;
            r_s1_a3   <= n_s1_a3;
            r_s2_a2   <= r_s1_a2;
            r_s2_a12  <= n_s2_a12;
            r_s2_a15  <= n_s2_a15;
            r_s3_a2   <= r_s2_a2;
            r_s3_a252 <= n_s3_a252;
            r_s4_sub  <= n_s4_sub;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_byte = r_s4_sub;

    `SBF_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_ctl.en && i_ctl.vld, r_vld[0])
    `SBF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_ctl.en, $stable(r_vld) && $stable(r_s4_sub))
    `SBF_ASSERT_NEXT(a_shift, i_clk, i_rst_n, i_ctl.en && r_vld[2], r_vld[3])

endmodule

>>> src/aes_sbox_forward.sv
// top level of the aes forward s-box: input skid register and handshakes
// depends on sbf_pkg, sbf_pipe and assert_macros.svh
//
// use: one byte request in on i_valid / o_stall with i_in_byte, one result
// out on o_valid / i_stall with o_sub_byte. a request is taken at a rising
// edge where i_valid is high and o_stall is low; a result likewise with
// o_valid high and i_stall low.
// each accepted byte passes through the datapath stages in order, each
// stage holding one gf(2^8) multiply of the a^254 chain, the last one
// also the affine map.
// throughput: one byte per cycle while the receiver keeps i_stall low.
// stall: when a result waits under i_stall the whole pipeline holds; a
// request taken in that cycle lands in a one-entry skid register and
// o_stall rises the next cycle until the pipeline moves again. o_stall is
// driven from a register only.
// reset: i_rst_n low at a clock edge clears all valid bits and the skid
// valid flag; no results are pending after reset.
`include "assert_macros.svh"

module aes_sbox_forward (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_sub_byte
);
    import sbf_pkg::*;

    logic       r_skid_vld;
    logic [7:0] r_skid_byte;
    logic       n_skid_vld;

    logic       w_en;
    logic       w_acc;
    logic       w_dp_vld;
    logic [7:0] w_dp_byte;
    logic [7:0] w_in_byte;
    t_dp_ctl    w_ctl;

    assign w_en      = !(w_dp_vld && i_stall);
    assign w_acc     = i_valid && !r_skid_vld;
    assign w_in_byte = r_skid_vld ? r_skid_byte : i_in_byte;

    always_comb begin
        w_ctl.en   = w_en;
        w_ctl.vld  = r_skid_vld || w_acc;
        n_skid_vld = w_en ? 1'b0 : (r_skid_vld || w_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_en) begin
            r_skid_byte <= i_in_byte;
        end
    end

    sbf_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (w_in_byte),
        .o_vld   (w_dp_vld),
        .o_byte  (w_dp_byte)
    );

    assign o_stall    = r_skid_vld;
    assign o_valid    = w_dp_vld;
    assign o_sub_byte = w_dp_byte;

    `SBF_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, i_valid && !o_stall && !w_en, r_skid_vld)
    `SBF_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld && w_en, !r_skid_vld)
    `SBF_ASSERT_NEXT(a_skid_keep, i_clk, i_rst_n, r_skid_vld && !w_en, $stable(r_skid_byte))

endmodule
